// ===== src/nca_pkg.sv =====
package nca_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIMS_DEF     = 64;
  localparam int VALUE_BITS_DEF   = 16;

  localparam int FUNC_W     = 1;
  localparam int CLUSTER_W  = 4;
  localparam int DIM_IDX_W  = 6;
  localparam int VALUE_W    = 16;
  localparam int LABEL_W    = 4;
  localparam int DIST_W     = 38;
  localparam int NUM_CL_W   = 5;
  localparam int DIMS_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS         = 2'd1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]           func;
    logic [CLUSTER_W-1:0]        cluster_index;
    logic [DIM_IDX_W-1:0]        dim_index;
    logic signed [VALUE_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [DIST_W-1:0]  distance_sq;
    logic               status;
  } out_item_t;

  // control that travels alongside each component product in the walk
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic fin;
  } walk_tag_t;

endpackage

// ===== src/nca_ram.sv =====
module nca_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/nca_dist.sv =====
module nca_dist #(
  parameter int VALUE_BITS = nca_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nca_pkg::walk_tag_t           tag_in,
  input  logic signed [VALUE_BITS-1:0] pnt,
  input  logic signed [VALUE_BITS-1:0] cen,
  output nca_pkg::walk_tag_t           tag_out,
  output logic [nca_pkg::DIST_W-1:0]   acc
);

  localparam int SQ_W  = 2 * (VALUE_BITS + 1);
  localparam int SUM_W = ((SQ_W > nca_pkg::DIST_W) ? SQ_W : nca_pkg::DIST_W) + 1;

  logic signed [VALUE_BITS:0]    diff;
  logic [VALUE_BITS:0]           mag;
  logic [SQ_W-1:0]               sq_nxt;
  logic [SQ_W-1:0]               sq_r;
  nca_pkg::walk_tag_t            t2_r;
  nca_pkg::walk_tag_t            t3_r;
  logic [nca_pkg::DIST_W-1:0]    acc_src;
  logic [SUM_W-1:0]              sum;
  logic [nca_pkg::DIST_W-1:0]    acc_nxt;
  logic [nca_pkg::DIST_W-1:0]    acc_r;

  assign diff   = {pnt[VALUE_BITS-1], pnt} - {cen[VALUE_BITS-1], cen};
  assign mag    = diff[VALUE_BITS] ? $unsigned(-diff) : $unsigned(diff);
  assign sq_nxt = mag * mag;

  // saturating accumulate; restart on the first component of a centroid
  assign acc_src = t2_r.first ? '0 : acc_r;
  assign sum     = SUM_W'(acc_src) + SUM_W'(sq_r);
  assign acc_nxt = (sum > SUM_W'(nca_pkg::DIST_MAX)) ? nca_pkg::DIST_MAX
                                                     : sum[nca_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t2_r <= tag_in;
      t3_r <= t2_r;
    end
    sq_r <= sq_nxt;
    if (t2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign tag_out = t3_r;
  assign acc     = acc_r;

endmodule

// ===== src/nearest_centroid_assign.sv =====
// Nearest-centroid assigner, squared L2. Loads (func 0) and query components
// that do not complete a point are taken without stalling. The query component with
// dim_index = dims-1 starts a walk over all num_clusters x dims component
// pairs through one shared subtract-square-accumulate unit, one pair per
// cycle behind the registered reads of the centroid and point memories, and a
// completing query holds the input stalled until its result is written to the
// result register; the walk is skipped when nothing was loaded since reset.
// The result register lets the next transaction be taken while a result still
// waits on the output.
module nearest_centroid_assign #(
  parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = nca_pkg::MAX_DIMS_DEF,
  parameter int VALUE_BITS   = nca_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nca_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nca_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nca_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CEN_AW = CL_W + DIM_W;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_t;

  function automatic logic [31:0] last_of(input logic [31:0] v, input int hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd0;
    end else if (v > 32'(hi)) begin
      r = 32'(hi - 1);
    end else begin
      r = v - 32'd1;
    end
    return r;
  endfunction

  state_t                          state_r;
  logic                            issuing_r;
  logic                            trained_r;
  logic [nca_pkg::NUM_CL_W-1:0]    num_clusters_r;
  logic [nca_pkg::DIMS_W-1:0]      dims_r;
  logic [CL_W-1:0]                 c_r;
  logic [DIM_W-1:0]                d_r;
  logic [CL_W-1:0]                 cmp_cl_r;
  logic [CL_W-1:0]                 best_cl_r;
  logic [nca_pkg::DIST_W-1:0]      best_d_r;
  logic                            status_r;
  logic                            out_valid_r;
  nca_pkg::out_item_t              out_data_r;
  nca_pkg::walk_tag_t              t1_r;
  nca_pkg::walk_tag_t              issue_tag;
  nca_pkg::walk_tag_t              t3;

  logic                            accept;
  logic [31:0]                     ci_ext;
  logic [31:0]                     di_ext;
  logic [31:0]                     val_ext;
  logic [31:0]                     nk_last_ext;
  logic [31:0]                     nd_last_ext;
  logic [31:0]                     label_ext;
  logic [CL_W-1:0]                 nk_last;
  logic [DIM_W-1:0]                nd_last;
  logic                            ci_ok;
  logic                            di_ok;
  logic                            is_load;
  logic                            cen_we;
  logic                            pnt_we;
  logic                            q_done;
  logic                            slot_free;
  logic [VALUE_BITS-1:0]           wr_val;
  logic [VALUE_BITS-1:0]           pnt_rd;
  logic [VALUE_BITS-1:0]           cen_rd;
  logic [nca_pkg::DIST_W-1:0]      acc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign ci_ext  = 32'(in_data.cluster_index);
  assign di_ext  = 32'(in_data.dim_index);
  // only the low VALUE_BITS of the 16-bit field are kept
  assign val_ext = {16'd0, in_data.value};
  assign wr_val  = val_ext[VALUE_BITS-1:0];

  assign nk_last_ext = last_of(32'(num_clusters_r), MAX_CLUSTERS);
  assign nd_last_ext = last_of(32'(dims_r), MAX_DIMS);
  assign nk_last     = nk_last_ext[CL_W-1:0];
  assign nd_last     = nd_last_ext[DIM_W-1:0];

  assign ci_ok   = ci_ext < 32'(MAX_CLUSTERS);
  assign di_ok   = di_ext < 32'(MAX_DIMS);
  assign is_load = (in_data.func == nca_pkg::FUNC_LOAD);
  assign cen_we  = accept && is_load && ci_ok && di_ok;
  assign pnt_we  = accept && !is_load && di_ok;
  assign q_done  = pnt_we && (di_ext == nd_last_ext);

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    issue_tag.vld   = (state_r == ST_WALK) && issuing_r;
    issue_tag.first = (d_r == '0);
    issue_tag.last  = (d_r == nd_last);
    issue_tag.fin   = (d_r == nd_last) && (c_r == nk_last);
  end

  nca_ram #(
    .WIDTH  (VALUE_BITS),
    .DEPTH  (1 << CEN_AW),
    .ADDR_W (CEN_AW)
  ) u_cen_ram (
    .clk     (clk),
    .wr_en   (cen_we),
    .wr_addr ({ci_ext[CL_W-1:0], di_ext[DIM_W-1:0]}),
    .wr_data (wr_val),
    .rd_addr ({c_r, d_r}),
    .rd_data (cen_rd)
  );

  nca_ram #(
    .WIDTH  (VALUE_BITS),
    .DEPTH  (MAX_DIMS),
    .ADDR_W (DIM_W)
  ) u_pnt_ram (
    .clk     (clk),
    .wr_en   (pnt_we),
    .wr_addr (di_ext[DIM_W-1:0]),
    .wr_data (wr_val),
    .rd_addr (d_r),
    .rd_data (pnt_rd)
  );

  nca_dist #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (t1_r),
    .pnt     ($signed(pnt_rd)),
    .cen     ($signed(cen_rd)),
    .tag_out (t3),
    .acc     (acc)
  );

  assign label_ext = 32'(best_cl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      issuing_r      <= 1'b0;
      trained_r      <= 1'b0;
      num_clusters_r <= nca_pkg::NUM_CL_W'(1);
      dims_r         <= nca_pkg::DIMS_W'(1);
      c_r            <= '0;
      d_r            <= '0;
      cmp_cl_r       <= '0;
      out_valid_r    <= 1'b0;
      t1_r           <= '0;
    end else begin
      t1_r <= issue_tag;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nca_pkg::CFG_NUM_CLUSTERS) begin
          num_clusters_r <= cfg_data[nca_pkg::NUM_CL_W-1:0];
        end else if (cfg_index == nca_pkg::CFG_DIMS) begin
          dims_r <= cfg_data;
        end
      end

      if (cen_we) begin
        trained_r <= 1'b1;
      end

      // in finish the result register is reloaded instead
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (q_done) begin
            if (trained_r) begin
              state_r   <= ST_WALK;
              issuing_r <= 1'b1;
              c_r       <= '0;
              d_r       <= '0;
              cmp_cl_r  <= '0;
              status_r  <= 1'b0;
            end else begin
              state_r   <= ST_FINISH;
              best_cl_r <= '0;
              best_d_r  <= '0;
              status_r  <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (issue_tag.vld) begin
            if (issue_tag.last) begin
              d_r <= '0;
              c_r <= c_r + 1'b1;
            end else begin
              d_r <= d_r + 1'b1;
            end
            if (issue_tag.fin) begin
              issuing_r <= 1'b0;
            end
          end
          if (t3.vld && t3.last) begin
            // strict less-than keeps the lower index on ties
            if ((cmp_cl_r == '0) || (acc < best_d_r)) begin
              best_d_r  <= acc;
              best_cl_r <= cmp_cl_r;
            end
            cmp_cl_r <= cmp_cl_r + 1'b1;
            if (t3.fin) begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_data_r.label       <= label_ext[nca_pkg::LABEL_W-1:0];
            out_data_r.distance_sq <= best_d_r;
            out_data_r.status      <= status_r;
            out_valid_r            <= 1'b1;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fin_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    t3.vld && t3.fin |=> state_r == ST_FINISH)
    else $error("last centroid compare did not end the walk");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !t1_r.vld && !t3.vld)
    else $error("walk pipeline busy while idle");

  a_walk_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    t1_r.vld |-> in_stall)
    else $error("input open during walk");

  a_untrained_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |->
      out_data_r.label == '0 && out_data_r.distance_sq == '0)
    else $error("not-trained result carries data");

endmodule

// ===== tb/nca_checker.sv =====
`timescale 1ns / 100ps

// Watches the three channels, keeps its own copy of the centroid store,
// point buffer and registers, and predicts each assignment result.
module nca_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  nca_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  nca_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [nca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nca_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             err_count,
  output int                             pending
);
  import nca_pkg::*;

  logic signed [VALUE_W-1:0] centroid_mem [MAX_CLUSTERS_DEF][MAX_DIMS_DEF];
  logic signed [VALUE_W-1:0] point_mem [MAX_DIMS_DEF];
  logic                      trained;
  logic [NUM_CL_W-1:0]       clusters_reg;
  logic [DIMS_W-1:0]         dims_reg;
  out_item_t                 expected_labels [$];
  out_item_t                 want;
  int                        mismatches = 0;
  int                        dim;

  assign err_count = mismatches;

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic out_item_t classify_point();
    out_item_t         res;
    int                nk;
    int                nd;
    longint            diff;
    longint unsigned   acc;
    longint unsigned   best;
    nk = clamp_count(int'(clusters_reg), MAX_CLUSTERS_DEF);
    nd = clamp_count(int'(dims_reg), MAX_DIMS_DEF);
    res = '0;
    best = 0;
    if (!trained) begin
      res.status = 1'b1;
      return res;
    end
    for (int c = 0; c < nk; c++) begin
      acc = 0;
      for (int d = 0; d < nd; d++) begin
        diff = longint'(point_mem[d]) - longint'(centroid_mem[c][d]);
        if (diff < 0) diff = -diff;
        acc += longint'(diff * diff);
        if (acc > DIST_MAX) acc = DIST_MAX;
      end
      // strict compare keeps the lower index on ties
      if (c == 0 || acc < best) begin
        best = acc;
        res.label = c[LABEL_W-1:0];
      end
    end
    res.distance_sq = best[DIST_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      trained = 1'b0;
      clusters_reg = NUM_CL_W'(1);
      dims_reg = DIMS_W'(1);
      expected_labels.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_CLUSTERS) clusters_reg = cfg_data[NUM_CL_W-1:0];
        else if (cfg_index == CFG_DIMS) dims_reg = cfg_data[DIMS_W-1:0];
      end

      if (out_valid && !out_stall) begin
        if (expected_labels.size() == 0) begin
          report_mismatch($sformatf("unexpected result label=%0d dist=%0d status=%0d",
                                    out_data.label, out_data.distance_sq, out_data.status));
        end else begin
          want = expected_labels.pop_front();
          if (out_data.label !== want.label)
            report_mismatch($sformatf("label %0d, expected %0d", out_data.label, want.label));
          if (out_data.distance_sq !== want.distance_sq)
            report_mismatch($sformatf("distance_sq %0d, expected %0d",
                                      out_data.distance_sq, want.distance_sq));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
        end
      end

      if (in_valid && !in_stall) begin
        dim = int'(in_data.dim_index);
        if (in_data.func == FUNC_LOAD) begin
          centroid_mem[in_data.cluster_index][dim] = $signed(in_data.value);
          trained = 1'b1;
        end else begin
          point_mem[dim] = $signed(in_data.value);
          if (dim == clamp_count(int'(dims_reg), MAX_DIMS_DEF) - 1)
            expected_labels = {expected_labels, classify_point()};
        end
      end

      pending <= expected_labels.size();
    end
  end

endmodule

// ===== tb/tb_nearest_centroid_assign.sv =====
`timescale 1ns / 100ps

module tb_nearest_centroid_assign;
  import nca_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 750;
  localparam int PHASE_ITEMS = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    err_count;
  int                    pending;

  int  cycle_count = 0;
  int  items_sent = 0;
  bit  sender_quiet = 1'b0;
  bit  recv_quiet = 1'b0;
  int  hold_cycles;
  bit  centroid_set [MAX_CLUSTERS_DEF][MAX_DIMS_DEF];
  bit  point_set [MAX_DIMS_DEF];
  int  order [MAX_DIMS_DEF];
  int  phase, nk_data, nd_data, cur_clusters, cur_dims;
  int  r, j, tmp, dim, phase_start;
  bit  full_scale, point_ready;

  nearest_centroid_assign dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  nca_checker chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .err_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_nearest_centroid_assign: errors");
      $finish;
    end
  end

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // extremes, small values that make ties likely, and full-range noise
  function automatic int pick_value();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2, 3: return int'($urandom_range(0, 16)) - 8;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [FUNC_W-1:0] func, int cl, int dm, int val);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.func <= func;
    in_data.cluster_index <= cl[CLUSTER_W-1:0];
    in_data.dim_index <= dm[DIM_IDX_W-1:0];
    in_data.value <= val[VALUE_W-1:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (func == FUNC_LOAD) centroid_set[cl][dm] = 1'b1;
    else point_set[dm] = 1'b1;
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold off the sender until every expected result is back
  task automatic settle(int tail);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // result side: random stall before each transaction, with quiet stretches
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 9) == 0) recv_quiet = !recv_quiet;
      hold_cycles = recv_quiet ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_CLUSTERS;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // nothing loaded yet: status only, at reset geometry and after a resize
    send_item(FUNC_QUERY, $urandom_range(0, 15), 0, 32767);
    settle(8);
    write_reg(CFG_DIMS, 3);
    write_reg(CFG_NUM_CLUSTERS, 2);
    send_item(FUNC_QUERY, $urandom_range(0, 15), 0, -1);
    send_item(FUNC_QUERY, $urandom_range(0, 15), 1, 0);
    send_item(FUNC_QUERY, $urandom_range(0, 15), 2, 1);

    // centroid 0 at the origin, centroid 1 at 10: midpoint is a tie
    for (int c = 0; c < 2; c++)
      for (int d = 0; d < 3; d++)
        send_item(FUNC_LOAD, c, d, c * 10);
    for (int d = 0; d < 3; d++) send_item(FUNC_QUERY, $urandom_range(0, 15), d, 5);
    for (int d = 0; d < 3; d++) send_item(FUNC_QUERY, $urandom_range(0, 15), d, 10);

    settle(8);
    write_reg(CFG_NUM_CLUSTERS, 1);
    write_reg(CFG_DIMS, 1);
    send_item(FUNC_LOAD, 0, 0, -32768);
    send_item(FUNC_QUERY, $urandom_range(0, 15), 0, 32767);

    // zero registers clamp to one; spare indexes have no effect
    settle(8);
    write_reg(CFG_NUM_CLUSTERS, 0);
    write_reg(CFG_DIMS, 0);
    write_reg(CFG_SPARE_LO, 7'h55);
    write_reg(CFG_SPARE_HI, 7'h2A);
    send_item(FUNC_QUERY, $urandom_range(0, 15), 0, 0);

    for (phase = 0; phase < 5 || items_sent < ITEM_TARGET; phase++) begin
      settle(8);
      case (phase)
        0: begin nk_data = 16;    nd_data = 1;   end
        1: begin nk_data = 7'h60; nd_data = 64;  end  // low bits zero: one centroid
        2: begin nk_data = 7'h3F; nd_data = 0;   end
        3: begin nk_data = 1;     nd_data = 127; end
        4: begin nk_data = 20;    nd_data = 2;   end
        default: begin
          nk_data = $urandom_range(1, 6) | ($urandom_range(0, 3) << 5);
          nd_data = $urandom_range(1, 8);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_NUM_CLUSTERS, nk_data);
        write_reg(CFG_DIMS, nd_data);
      end else begin
        write_reg(CFG_DIMS, nd_data);
        write_reg(CFG_NUM_CLUSTERS, nk_data);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom_range(0, 127));
      cur_clusters = clamp_count(nk_data & 31, MAX_CLUSTERS_DEF);
      cur_dims = clamp_count(nd_data, MAX_DIMS_DEF);
      full_scale = (phase == 3);
      sender_quiet = ($urandom_range(0, 3) == 0);

      // every centroid entry the search will read must be written first
      for (int c = 0; c < cur_clusters; c++)
        for (int d = 0; d < cur_dims; d++)
          if (!centroid_set[c][d] || full_scale)
            send_item(FUNC_LOAD, c, d, full_scale ? -32768 : pick_value());

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        r = full_scale ? 0 : $urandom_range(0, 99);
        if (r < 70) begin
          // whole point, components shuffled, completing component last
          for (int i = 0; i < cur_dims - 1; i++) order[i] = i;
          for (int i = cur_dims - 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          order[cur_dims - 1] = cur_dims - 1;
          for (int i = 0; i < cur_dims; i++)
            send_item(FUNC_QUERY, $urandom_range(0, 15), order[i],
                      full_scale ? 32767 : pick_value());
          full_scale = 1'b0;
        end else if (r < 85) begin
          send_item(FUNC_LOAD, $urandom_range(0, 15), $urandom_range(0, 63), pick_value());
        end else begin
          // stray component; completes only if the point buffer is filled
          dim = $urandom_range(0, 63);
          point_ready = 1'b1;
          for (int d = 0; d < cur_dims - 1; d++)
            if (!point_set[d]) point_ready = 1'b0;
          if (dim == cur_dims - 1 && !point_ready) dim = $urandom_range(0, cur_dims - 2);
          send_item(FUNC_QUERY, $urandom_range(0, 15), dim, pick_value());
        end
      end
    end

    settle(64);
    if (err_count == 0)
      $display("tb_nearest_centroid_assign: clean");
    else
      $display("tb_nearest_centroid_assign: errors");
    $finish;
  end

endmodule
